FILE: src/bgu_pkg.sv
package bgu_pkg;

    localparam int MAX_COLS_DEF = 4096;
    localparam int MAX_RATE     = 7;
    localparam int GRID_LIMIT   = 4096;
    localparam int ROW_W        = 12;
    localparam int POS_W        = 15;
    localparam int JOB_DEPTH    = 2;
    localparam int OUT_DEPTH    = 8;

    localparam logic [1:0] CFG_RATE = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_COLS = 2'd2;

    localparam logic [2:0]  RATE_RST = 3'd2;
    localparam logic [12:0] ROWS_RST = 13'd3601;
    localparam logic [12:0] COLS_RST = 13'd3601;

    typedef struct packed {
        logic [2:0]  rate;
        logic [12:0] rows;
        logic [12:0] cols;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] h00;
        logic signed [15:0] h01;
        logic signed [15:0] h10;
        logic signed [15:0] h11;
        logic [POS_W-1:0]   base_row;
        logic [POS_W-1:0]   base_col;
        logic [2:0]         bi_max;
        logic [2:0]         bj_max;
        logic [2:0]         rate;
    } job_t;

    typedef struct packed {
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic signed [15:0] height;
        logic               last;
    } point_t;

endpackage

FILE: src/bgu_ram.sv
module bgu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

FILE: src/bgu_fifo.sv
module bgu_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign count    = count_reg;
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/bgu_front.sv
module bgu_front #(
    parameter int MAX_COLS = bgu_pkg::MAX_COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] sample,
    input  bgu_pkg::cfg_t      cfg,
    input  logic               job_full,
    output logic               job_push,
    output bgu_pkg::job_t      job_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int PW = bgu_pkg::POS_W;
    localparam int RW = bgu_pkg::ROW_W;

    typedef enum logic {
        F_IDLE,
        F_FETCH
    } fstate_t;

    fstate_t            state_reg;
    logic [RW-1:0]      row_pos_reg;
    logic [CW-1:0]      col_pos_reg;
    logic signed [15:0] s_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] upper_left_reg;
    logic [RW-1:0]      r_reg;
    logic [CW-1:0]      c_reg;
    logic               emit_reg;
    logic               last_row_reg;
    logic               last_col_reg;

    logic               accept;
    logic               wrap;
    logic [PW-1:0]      cols_ext;
    logic [PW-1:0]      rows_ext;
    logic [PW-1:0]      r_ext;
    logic [PW-1:0]      r_use;
    logic [PW-1:0]      r_inc;
    logic [PW-1:0]      c_inc;
    logic [CW-1:0]      c_use;
    logic [RW-1:0]      row_next;
    logic [CW-1:0]      col_next;
    logic [15:0]        above;
    logic [RW-1:0]      r_m1;
    logic [CW-1:0]      c_m1;

    assign full   = (state_reg != F_IDLE) || job_full;
    assign accept = push && !full;

    assign cols_ext = PW'(cfg.cols);
    assign rows_ext = PW'(cfg.rows);
    assign wrap     = (PW'(col_pos_reg) >= cols_ext);
    assign c_use    = wrap ? '0 : col_pos_reg;
    assign r_ext    = PW'(row_pos_reg) + PW'(wrap);
    assign r_use    = (r_ext >= rows_ext) ? '0 : r_ext;
    assign c_inc    = PW'(c_use) + PW'(1);
    assign r_inc    = r_use + PW'(1);

    always_comb
    begin
        if (c_inc >= cols_ext)
        begin
            col_next = '0;
            row_next = (r_inc >= rows_ext) ? '0 : r_inc[RW-1:0];
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            row_next = r_use[RW-1:0];
        end
    end

    bgu_ram #(
        .WIDTH (16),
        .DEPTH (MAX_COLS)
    ) u_line (
        .clk     (clk),
        .we      (accept),
        .wr_addr (c_use),
        .wr_data (sample),
        .re      (accept),
        .rd_addr (c_use),
        .rd_data (above)
    );

    assign r_m1 = r_reg - RW'(1);
    assign c_m1 = c_reg - CW'(1);

    always_comb
    begin
        job_data.h00      = upper_left_reg;
        job_data.h01      = $signed(above);
        job_data.h10      = left_reg;
        job_data.h11      = s_reg;
        job_data.base_row = PW'(r_m1) * PW'(cfg.rate);
        job_data.base_col = PW'(c_m1) * PW'(cfg.rate);
        job_data.bi_max   = last_row_reg ? cfg.rate : cfg.rate - 3'd1;
        job_data.bj_max   = last_col_reg ? cfg.rate : cfg.rate - 3'd1;
        job_data.rate     = cfg.rate;
    end

    assign job_push = (state_reg == F_FETCH) && emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            s_reg          <= '0;
            left_reg       <= '0;
            upper_left_reg <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            emit_reg       <= 1'b0;
            last_row_reg   <= 1'b0;
            last_col_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg    <= F_FETCH;
                        s_reg        <= sample;
                        r_reg        <= r_use[RW-1:0];
                        c_reg        <= c_use;
                        emit_reg     <= (r_use != '0) && (c_use != '0);
                        last_row_reg <= (r_use == rows_ext - PW'(1));
                        last_col_reg <= (PW'(c_use) == cols_ext - PW'(1));
                        row_pos_reg  <= row_next;
                        col_pos_reg  <= col_next;
                    end
                end
                F_FETCH:
                begin
                    state_reg      <= F_IDLE;
                    upper_left_reg <= $signed(above);
                    left_reg       <= s_reg;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/bgu_back.sv
module bgu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_empty,
    input  bgu_pkg::job_t      job,
    output logic               job_pop,
    output logic               empty,
    input  logic               pop,
    output logic [14:0]        out_row,
    output logic [14:0]        out_col,
    output logic signed [15:0] height,
    output logic               last_of_run
);

    localparam int PW    = bgu_pkg::POS_W;
    localparam int DEPTH = bgu_pkg::OUT_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [24:0] recip(input logic [2:0] r);
        logic [24:0] m;
        case (r)
            3'd1:    m = 25'd16777216;
            3'd2:    m = 25'd4194304;
            3'd3:    m = 25'd1864135;
            3'd4:    m = 25'd1048576;
            3'd5:    m = 25'd671088;
            3'd6:    m = 25'd466033;
            3'd7:    m = 25'd342392;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

    bgu_pkg::job_t      job_reg;
    logic               busy_reg;
    logic [2:0]         bi_reg;
    logic [2:0]         bj_reg;

    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               s3_valid_reg;
    logic               s4_valid_reg;

    logic signed [15:0] s1_h00_reg;
    logic signed [15:0] s1_h01_reg;
    logic signed [15:0] s1_h10_reg;
    logic signed [15:0] s1_h11_reg;
    logic [5:0]         s1_w00_reg;
    logic [5:0]         s1_w01_reg;
    logic [5:0]         s1_w10_reg;
    logic [5:0]         s1_w11_reg;
    logic [2:0]         s1_rate_reg;
    bgu_pkg::point_t    s1_meta_reg;

    logic signed [22:0] s2_p00_reg;
    logic signed [22:0] s2_p01_reg;
    logic signed [22:0] s2_p10_reg;
    logic signed [22:0] s2_p11_reg;
    logic [2:0]         s2_rate_reg;
    bgu_pkg::point_t    s2_meta_reg;

    logic [20:0]        s3_x_reg;
    logic               s3_neg_reg;
    logic [2:0]         s3_rate_reg;
    bgu_pkg::point_t    s3_meta_reg;

    logic [16:0]        s4_q0_reg;
    logic [20:0]        s4_x_reg;
    logic               s4_neg_reg;
    logic [2:0]         s4_rate_reg;
    bgu_pkg::point_t    s4_meta_reg;

    logic [CNT_W-1:0]   out_count;
    logic [2:0]         inflight;
    logic               room;
    logic               issue;
    logic               last_pt;
    logic [2:0]         wi0;
    logic [2:0]         wj0;
    logic signed [24:0] num;
    logic signed [24:0] num_abs;
    logic [45:0]        prod;
    logic [5:0]         dsq;
    logic [22:0]        qd;
    logic [22:0]        rem;
    logic [16:0]        q;
    logic [16:0]        q_signed;
    bgu_pkg::point_t    result;
    bgu_pkg::point_t    head;

    assign inflight = 3'($countones({s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg}));
    assign room     = ((CNT_W + 1)'(out_count) + (CNT_W + 1)'(inflight)) < (CNT_W + 1)'(DEPTH);
    assign issue    = busy_reg && room;
    assign last_pt  = (bi_reg == job_reg.bi_max) && (bj_reg == job_reg.bj_max);
    assign job_pop  = !job_empty && (!busy_reg || (issue && last_pt));

    assign wi0 = job_reg.rate - bi_reg;
    assign wj0 = job_reg.rate - bj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            bi_reg       <= '0;
            bj_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (job_pop)
            begin
                busy_reg <= 1'b1;
                bi_reg   <= '0;
                bj_reg   <= '0;
            end
            else if (issue)
            begin
                if (bj_reg == job_reg.bj_max)
                begin
                    bj_reg <= '0;
                    if (bi_reg == job_reg.bi_max)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        bi_reg <= bi_reg + 3'd1;
                    end
                end
                else
                begin
                    bj_reg <= bj_reg + 3'd1;
                end
            end
        end
    end

    assign num     = 25'(s2_p00_reg) + 25'(s2_p01_reg) + 25'(s2_p10_reg) + 25'(s2_p11_reg);
    assign num_abs = num[24] ? -num : num;
    assign prod    = 46'(s3_x_reg) * 46'(recip(s3_rate_reg));

    assign dsq      = 6'(s4_rate_reg) * 6'(s4_rate_reg);
    assign qd       = 23'(s4_q0_reg) * 23'(dsq);
    assign rem      = 23'(s4_x_reg) - qd;
    assign q        = s4_q0_reg + 17'(rem >= 23'(dsq));
    assign q_signed = s4_neg_reg ? -q : q;

    always_comb
    begin
        result        = s4_meta_reg;
        result.height = $signed(q_signed[15:0]);
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end

        s1_h00_reg          <= job_reg.h00;
        s1_h01_reg          <= job_reg.h01;
        s1_h10_reg          <= job_reg.h10;
        s1_h11_reg          <= job_reg.h11;
        s1_w00_reg          <= 6'(wi0) * 6'(wj0);
        s1_w01_reg          <= 6'(wi0) * 6'(bj_reg);
        s1_w10_reg          <= 6'(bi_reg) * 6'(wj0);
        s1_w11_reg          <= 6'(bi_reg) * 6'(bj_reg);
        s1_rate_reg         <= job_reg.rate;
        s1_meta_reg.row     <= job_reg.base_row + PW'(bi_reg);
        s1_meta_reg.col     <= job_reg.base_col + PW'(bj_reg);
        s1_meta_reg.height  <= '0;
        s1_meta_reg.last    <= last_pt;

        s2_p00_reg  <= s1_h00_reg * $signed({1'b0, s1_w00_reg});
        s2_p01_reg  <= s1_h01_reg * $signed({1'b0, s1_w01_reg});
        s2_p10_reg  <= s1_h10_reg * $signed({1'b0, s1_w10_reg});
        s2_p11_reg  <= s1_h11_reg * $signed({1'b0, s1_w11_reg});
        s2_rate_reg <= s1_rate_reg;
        s2_meta_reg <= s1_meta_reg;

        s3_x_reg    <= num_abs[20:0];
        s3_neg_reg  <= num[24];
        s3_rate_reg <= s2_rate_reg;
        s3_meta_reg <= s2_meta_reg;

        s4_q0_reg   <= prod[40:24];
        s4_x_reg    <= s3_x_reg;
        s4_neg_reg  <= s3_neg_reg;
        s4_rate_reg <= s3_rate_reg;
        s4_meta_reg <= s3_meta_reg;
    end

    bgu_fifo #(
        .WIDTH ($bits(bgu_pkg::point_t)),
        .DEPTH (DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_valid_reg),
        .push_data (result),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty),
        .full      (),
        .count     (out_count)
    );

    assign out_row     = head.row;
    assign out_col     = head.col;
    assign height      = head.height;
    assign last_of_run = head.last;

endmodule

FILE: src/bilinear_grid_upsampler.sv
// Bilinear upsampler for a grid of signed 16-bit elevation samples.
// Samples enter in row-major order on push/full; a beat is taken when push
// is high and full is low. Upsampled points leave on empty/pop; the oldest
// point sits on out_row, out_col, height and last_of_run while empty is low.
// Registers are written through cfg_we, cfg_index and cfg_data; index 0
// is rate, 1 is rows_in_use, 2 is cols_in_use. The user must write them only
// while the block is idle; the block itself does not enforce this.
// The front end accepts a sample in F_IDLE, where it reads the line store
// port, and forms the cell job in F_FETCH. Samples in the first row or first
// column produce no points. Every other sample yields rate squared points,
// or more on the last row and column, which the back end emits at one point
// per cycle while its output queue has room, through a four-stage datapath.
// At the default rate of 2 the back end's output rate is what paces the samples.
// Reset clears the grid position, the corner registers and all queues; the
// line store is not cleared and needs no clearing pass. When the receiver
// stalls, the output queue fills, the back end stops issuing points, the
// job queue fills and full is raised until room frees up again.
module bilinear_grid_upsampler #(
    parameter int MAX_COLS = bgu_pkg::MAX_COLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] sample,
    output logic               empty,
    input  logic               pop,
    output logic [14:0]        out_row,
    output logic [14:0]        out_col,
    output logic signed [15:0] height,
    output logic               last_of_run,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_data
);

    localparam int COL_HI = (MAX_COLS < bgu_pkg::GRID_LIMIT) ? MAX_COLS : bgu_pkg::GRID_LIMIT;

    logic [2:0]    rate_reg;
    logic [12:0]   rows_reg;
    logic [12:0]   cols_reg;
    bgu_pkg::cfg_t cfg;

    bgu_pkg::job_t job_in;
    bgu_pkg::job_t job_out;
    logic          job_push;
    logic          job_pop;
    logic          job_full;
    logic          job_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= bgu_pkg::RATE_RST;
            rows_reg <= bgu_pkg::ROWS_RST;
            cols_reg <= bgu_pkg::COLS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bgu_pkg::CFG_RATE: rate_reg <= cfg_data[2:0];
                bgu_pkg::CFG_ROWS: rows_reg <= cfg_data;
                bgu_pkg::CFG_COLS: cols_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (rate_reg == 3'd0)
        begin
            cfg.rate = 3'd1;
        end
        else if (rate_reg > 3'(bgu_pkg::MAX_RATE))
        begin
            cfg.rate = 3'(bgu_pkg::MAX_RATE);
        end
        else
        begin
            cfg.rate = rate_reg;
        end

        if (rows_reg < 13'd2)
        begin
            cfg.rows = 13'd2;
        end
        else if (rows_reg > 13'(bgu_pkg::GRID_LIMIT))
        begin
            cfg.rows = 13'(bgu_pkg::GRID_LIMIT);
        end
        else
        begin
            cfg.rows = rows_reg;
        end

        if (cols_reg < 13'd2)
        begin
            cfg.cols = 13'd2;
        end
        else if (cols_reg > 13'(COL_HI))
        begin
            cfg.cols = 13'(COL_HI);
        end
        else
        begin
            cfg.cols = cols_reg;
        end
    end

    bgu_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .sample   (sample),
        .cfg      (cfg),
        .job_full (job_full),
        .job_push (job_push),
        .job_data (job_in)
    );

    bgu_fifo #(
        .WIDTH ($bits(bgu_pkg::job_t)),
        .DEPTH (bgu_pkg::JOB_DEPTH)
    ) u_job_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .pop_data  (job_out),
        .empty     (job_empty),
        .full      (job_full),
        .count     ()
    );

    bgu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_empty   (job_empty),
        .job         (job_out),
        .job_pop     (job_pop),
        .empty       (empty),
        .pop         (pop),
        .out_row     (out_row),
        .out_col     (out_col),
        .height      (height),
        .last_of_run (last_of_run)
    );

    a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("Cell job pushed into a full job queue.");

    a_job_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_empty)
        else $error("Back end took a job from an empty job queue.");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("Front end took a beat while the line store read was pending.");

endmodule

FILE: tb/sv/bilinear_grid_upsampler_tb.sv
`timescale 1ns / 1ps

module bilinear_grid_upsampler_tb;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 32;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 250;
    localparam int QUIET_AFTER    = 200;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic                     is_reg;
        logic [1:0]               idx;
        logic [12:0]              val;
        logic signed [15:0]       smp;
        logic                     typed;
        logic [2:0]               n_pts;
        bgu_pkg::point_t [3:0]    pts;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [15:0] sample = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [14:0]        out_row;
    logic [14:0]        out_col;
    logic signed [15:0] height;
    logic               last_of_run;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = bgu_pkg::CFG_RATE;
    logic [12:0]        cfg_data = '0;

    logic [2:0]         reg_rate;
    logic [12:0]        reg_rows;
    logic [12:0]        reg_cols;
    logic signed [15:0] prev_row [0:bgu_pkg::MAX_COLS_DEF-1];
    logic signed [15:0] left_h;
    logic signed [15:0] upleft_h;
    int                 row_at;
    int                 col_at;
    int                 row_hw;

    bgu_pkg::point_t    pending_pts [$];
    stim_row_t          directed_rows [$];

    int errors = 0;
    int samples_sent = 0;
    int points_seen = 0;
    int reg_writes = 0;
    int phases = 0;
    int stuck_cycles = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    bilinear_grid_upsampler u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .out_row     (out_row),
        .out_col     (out_col),
        .height      (height),
        .last_of_run (last_of_run),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = ~clk;
    end

    function automatic int clamp_dim(input logic [12:0] v);
        if (v < 2)
            return 2;
        if (v > bgu_pkg::GRID_LIMIT)
            return bgu_pkg::GRID_LIMIT;
        return int'(v);
    endfunction

    function automatic int eff_rate(input logic [2:0] v);
        return (v == 3'd0) ? 1 : int'(v);
    endfunction

    function automatic logic signed [15:0] blend(input logic signed [15:0] h00, h01, h10, h11,
                                                 input int bi, bj, r);
        longint c00;
        longint c10;
        longint c01;
        longint c11;
        longint acc;
        c00 = longint'(h00);
        c10 = longint'(h01) - longint'(h00);
        c01 = longint'(h10) - longint'(h00);
        c11 = longint'(h00) - longint'(h01) - longint'(h10) + longint'(h11);
        acc = c00 * r * r + c10 * bj * r + c01 * bi * r + c11 * bi * bj;
        return 16'(acc / longint'(r * r));
    endfunction

    function automatic bgu_pkg::point_t pt(input int r, input int c,
                                           input logic signed [15:0] h, input bit l);
        bgu_pkg::point_t p;
        p.row = 15'(r);
        p.col = 15'(c);
        p.height = h;
        p.last = l;
        return p;
    endfunction

    function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [12:0] val);
        stim_row_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    function automatic stim_row_t smp_row(input logic signed [15:0] v);
        stim_row_t s;
        s = '0;
        s.smp = v;
        return s;
    endfunction

    function automatic stim_row_t none_row(input logic signed [15:0] v);
        stim_row_t s;
        s = '0;
        s.smp = v;
        s.typed = 1'b1;
        return s;
    endfunction

    function automatic stim_row_t cell_row(input logic signed [15:0] v,
                                           input bgu_pkg::point_t p0, p1, p2, p3);
        stim_row_t s;
        s = '0;
        s.smp = v;
        s.typed = 1'b1;
        s.n_pts = 3'd4;
        s.pts[0] = p0;
        s.pts[1] = p1;
        s.pts[2] = p2;
        s.pts[3] = p3;
        return s;
    endfunction

    function automatic logic signed [15:0] rand_height();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic upsample_cell(input logic signed [15:0] s, input bit keep);
        int r_e;
        int rows_e;
        int cols_e;
        int r;
        int c;
        int bi_max;
        int bj_max;
        logic signed [15:0] above;
        bgu_pkg::point_t p;
        r_e = eff_rate(reg_rate);
        rows_e = clamp_dim(reg_rows);
        cols_e = clamp_dim(reg_cols);
        r = row_at;
        c = col_at;
        if (c >= cols_e)
        begin
            c = 0;
            r++;
        end
        if (r >= rows_e)
            r = 0;
        above = prev_row[c];
        if (r >= 1 && c >= 1)
        begin
            bi_max = (r == rows_e - 1) ? r_e : r_e - 1;
            bj_max = (c == cols_e - 1) ? r_e : r_e - 1;
            for (int bi = 0; bi <= bi_max; bi++)
            begin
                for (int bj = 0; bj <= bj_max; bj++)
                begin
                    p.row = 15'(r_e * (r - 1) + bi);
                    p.col = 15'(r_e * (c - 1) + bj);
                    p.height = blend(upleft_h, above, left_h, s, bi, bj, r_e);
                    p.last = (bi == bi_max && bj == bj_max);
                    if (keep)
                        pending_pts.push_back(p);
                end
            end
        end
        upleft_h = above;
        prev_row[c] = s;
        left_h = s;
        if (c + 1 > row_hw)
            row_hw = c + 1;
        c++;
        if (c >= cols_e)
        begin
            c = 0;
            r++;
            if (r >= rows_e)
                r = 0;
        end
        row_at = r;
        col_at = c;
    endtask

    task automatic send_sample(input logic signed [15:0] s, input bit keep);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            push = 1'b0;
            sample = 16'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push = 1'b1;
        sample = s;
        do
            @(posedge clk);
        while (full);
        samples_sent++;
        upsample_cell(s, keep);
    endtask

    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        case (idx)
            bgu_pkg::CFG_RATE: reg_rate = val[2:0];
            bgu_pkg::CFG_ROWS: reg_rows = val;
            bgu_pkg::CFG_COLS: reg_cols = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        int idle_left;
        int held;
        idle_left = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop = 1'b0;
                held++;
                if (held >= HOLD_CYCLES)
                begin
                    hold_req = 1'b0;
                    held = 0;
                end
            end
            else if (idle_left > 0 && !quiet)
            begin
                pop = 1'b0;
                idle_left--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                pop = 1'b0;
                idle_left = $urandom_range(1, 19) - 1;
            end
            else
                pop = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        bgu_pkg::point_t want;
        if (rst_n && pop && !empty)
        begin
            points_seen++;
            if (pending_pts.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("unexpected point: row %0d col %0d height %0d last %0b",
                             out_row, out_col, height, last_of_run);
                errors++;
            end
            else
            begin
                want = pending_pts.pop_front();
                if (out_row !== want.row || out_col !== want.col ||
                    height !== want.height || last_of_run !== want.last)
                begin
                    if (errors < MAX_REPORTS)
                        $display(
                            "point %0d: expected r%0d c%0d h%0d l%0b, got r%0d c%0d h%0d l%0b",
                            points_seen, want.row, want.col, $signed(want.height),
                            want.last, out_row, out_col, height, last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_we)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", stuck_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   row_i;
        bit          prev_reg;
        bit          big;
        logic [2:0]  new_rate;
        logic [12:0] rows_v;
        logic [12:0] cols_v;
        int          random_sent;
        int          frames_left;
        int          burst;
        int          r_chk;
        int          c_chk;

        for (int i = 0; i < bgu_pkg::MAX_COLS_DEF; i++)
            prev_row[i] = '0;
        reg_rate = bgu_pkg::RATE_RST;
        reg_rows = bgu_pkg::ROWS_RST;
        reg_cols = bgu_pkg::COLS_RST;
        left_h = '0;
        upleft_h = '0;
        row_at = 0;
        col_at = 0;
        row_hw = 0;

        directed_rows.push_back(none_row(16'sd100));
        directed_rows.push_back(none_row(-16'sd5));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_RATE, 13'd1));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_ROWS, 13'd2));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_COLS, 13'd2));
        directed_rows.push_back(none_row(16'sd32767));
        directed_rows.push_back(cell_row(-16'sd32768, pt(0, 0, 16'sd100, 0),
                                         pt(0, 1, -16'sd5, 0), pt(1, 0, 16'sd32767, 0),
                                         pt(1, 1, -16'sd32768, 1)));
        directed_rows.push_back(none_row(-16'sd32768));
        directed_rows.push_back(none_row(16'sd32767));
        directed_rows.push_back(none_row(16'sd32767));
        directed_rows.push_back(cell_row(-16'sd32768, pt(0, 0, -16'sd32768, 0),
                                         pt(0, 1, 16'sd32767, 0), pt(1, 0, 16'sd32767, 0),
                                         pt(1, 1, -16'sd32768, 1)));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_RATE, 13'd0));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_ROWS, 13'd0));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_COLS, 13'd1));
        directed_rows.push_back(none_row(16'sd21845));
        directed_rows.push_back(none_row(-16'sd21846));
        directed_rows.push_back(none_row(-16'sd21846));
        directed_rows.push_back(cell_row(16'sd21845, pt(0, 0, 16'sd21845, 0),
                                         pt(0, 1, -16'sd21846, 0), pt(1, 0, -16'sd21846, 0),
                                         pt(1, 1, 16'sd21845, 1)));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_RATE, 13'd7));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_ROWS, 13'd4096));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_COLS, 13'd8191));
        directed_rows.push_back(none_row(16'sd7));
        directed_rows.push_back(none_row(-16'sd7));
        directed_rows.push_back(none_row(16'sd12345));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_COLS, 13'd2));
        directed_rows.push_back(smp_row(-16'sd20000));
        directed_rows.push_back(smp_row(16'sd30000));
        directed_rows.push_back(smp_row(-16'sd1234));
        directed_rows.push_back(smp_row(16'sd4321));
        directed_rows.push_back(reg_row(bgu_pkg::CFG_ROWS, 13'd2));
        directed_rows.push_back(smp_row(-16'sd32768));
        directed_rows.push_back(smp_row(16'sd32767));
        directed_rows.push_back(smp_row(16'sd32767));
        directed_rows.push_back(smp_row(-16'sd32768));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        prev_reg = 1'b0;
        foreach (directed_rows[i])
        begin
            row_i = directed_rows[i];
            if (row_i.is_reg)
            begin
                if (!prev_reg)
                    settle();
                write_reg(row_i.idx, row_i.val);
                prev_reg = 1'b1;
            end
            else
            begin
                send_sample(row_i.smp, !row_i.typed);
                if (row_i.typed)
                    for (int k = 0; k < row_i.n_pts; k++)
                        pending_pts.push_back(row_i.pts[k]);
                prev_reg = 1'b0;
            end
        end

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            new_rate = 3'($urandom_range(0, 7));
            big = ($urandom_range(0, 9) == 0);
            if (big)
            begin
                rows_v = 13'($urandom_range(0, 8191));
                cols_v = 13'($urandom_range(4090, 8191));
            end
            else
            begin
                rows_v = 13'($urandom_range(0, 5));
                cols_v = 13'($urandom_range(0, 6));
            end
            if (phases == 2)
            begin
                new_rate = 3'd3;
                rows_v = 13'd4;
                cols_v = 13'd5;
                big = 1'b0;
            end
            // A row past the first must never read a line entry that no row has written.
            r_chk = row_at;
            c_chk = col_at;
            if (c_chk >= clamp_dim(cols_v))
            begin
                c_chk = 0;
                r_chk++;
            end
            if (r_chk >= clamp_dim(rows_v))
                r_chk = 0;
            if (r_chk >= 1 && clamp_dim(cols_v) > row_hw)
                cols_v = 13'(row_hw);

            write_reg(bgu_pkg::CFG_RATE, {10'd0, new_rate});
            write_reg(bgu_pkg::CFG_ROWS, rows_v);
            write_reg(bgu_pkg::CFG_COLS, cols_v);
            if (phases == 2)
                hold_req = 1'b1;

            if (!big && (phases == 2 || $urandom_range(0, 4) != 0))
            begin
                frames_left = (phases == 2) ? 2 : 1;
                while (frames_left > 0)
                begin
                    send_sample(rand_height(), 1'b1);
                    random_sent++;
                    if (row_at == 0 && col_at == 0)
                        frames_left--;
                end
            end
            else
            begin
                burst = $urandom_range(1, 12);
                repeat (burst)
                begin
                    send_sample(rand_height(), 1'b1);
                    random_sent++;
                end
            end
            if (random_sent >= QUIET_AFTER)
                quiet = 1'b1;
            phases++;
        end

        quiet = 1'b1;
        @(negedge clk);
        push = 1'b0;
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        errors += pending_pts.size();

        $display("Streamed %0d samples through %0d grid settings with %0d register writes.",
                 samples_sent, phases + 5, reg_writes);
        $display("Compared %0d upsampled points; %0d mismatches.", points_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: bilinear_grid_upsampler.f
src/bgu_pkg.sv
src/bgu_ram.sv
src/bgu_fifo.sv
src/bgu_front.sv
src/bgu_back.sv
src/bilinear_grid_upsampler.sv
tb/sv/bilinear_grid_upsampler_tb.sv
